// ----- rtl/core/mzsp_pkg.sv -----
// Shared types and constants of the multi-zone sample player.
package mzsp_pkg;

  // Request codes carried by req_type
  typedef enum logic [2:0] {
    REQ_WRITE_SAMPLE = 3'd0,
    REQ_WRITE_ZONE   = 3'd1,
    REQ_START_PITCH  = 3'd2,
    REQ_START_RATE   = 3'd3,
    REQ_STOP         = 3'd4,
    REQ_TICK         = 3'd5,
    REQ_NOP6         = 3'd6,
    REQ_NOP7         = 3'd7
  } req_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TK_ZONE,
    ST_TK_POS,
    ST_TK_RDLO,
    ST_TK_RDUP,
    ST_TK_MUL,
    ST_TK_SUM,
    ST_FIN
  } state_e;

  // Configuration register indexes
  localparam logic CFG_LOOP_MODE  = 1'b0;
  localparam logic CFG_ZONE_COUNT = 1'b1;

  // Zone descriptor as stored in the zone memory
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] length;
    logic [15:0] loop_pt;
    logic [23:0] pitch;
  } zone_t;

  localparam logic [24:0] SEARCH_BOUND = 25'd25600000;  // 100000 Hz in Q17.8
  localparam logic [23:0] RATE_MAX     = 24'hFFFFFF;
  localparam logic [23:0] RATE_ONE     = 24'h010000;

endpackage

// ----- rtl/core/multi_zone_sample_player.sv -----
// Multi-zone sample player: top level with sample and zone memories and sequencer.
// One transaction per request; a request is taken only while the sequencer is idle.
// Writes, stop and start with rate go straight to the final state; a tick while playing
// steps through zone read, position update, two sample memory reads on one port, multiply
// and sum; a start by pitch reads and compares each searched zone, then waits on the
// bit-serial rate divider (skipped when the chosen base pitch is zero).
// Results go to an output register, so the next request is
// taken while a result still waits. SAMPLE_DEPTH must be a power of two; frame
// addresses wrap modulo the depth.
module multi_zone_sample_player
  import mzsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int NUM_ZONES    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [15:0]        mem_address_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [2:0]         zone_number_i,
  input  logic [15:0]        zone_base_i,
  input  logic [16:0]        zone_length_i,
  input  logic [15:0]        loop_point_i,
  input  logic [23:0]        base_pitch_i,
  input  logic [23:0]        note_pitch_i,
  input  logic [23:0]        rate_value_i,
  input  logic [23:0]        rate_modifier_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_out_o,
  output logic               is_playing_o,
  output logic [2:0]         active_zone_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW   = $clog2(SAMPLE_DEPTH);
  localparam int ZW   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int SUMW = (AW > 18) ? AW : 18;
  localparam int CW   = (ZW > 4) ? ZW + 1 : 5;

  // Configuration registers
  logic       loop_mode_q;
  logic [3:0] zone_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q  <= 1'b0;
      zone_count_q <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        CFG_LOOP_MODE:  loop_mode_q  <= pwdata[0];
        CFG_ZONE_COUNT: zone_count_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {28'd0, zone_count_q} : {31'd0, loop_mode_q};

  // Sequencer and play state
  state_e       state_q, state_d;
  logic [31:0]  pos_q;
  logic         not_started_q;
  logic         playing_q;
  logic [23:0]  rate_q;
  logic [ZW-1:0] sel_q;
  logic         out_valid_q;
  logic signed [15:0] out_sample_q;
  logic         out_playing_q;
  logic [2:0]   out_zone_q;

  // Item and working registers
  logic [23:0]  note_q, mod_q;
  logic [ZW-1:0] srch_idx_q, best_idx_q;
  logic [24:0]  smallest_q;
  logic [23:0]  best_pitch_q;
  logic [47:0]  prod_q;
  logic [16:0]  last_q;
  logic [15:0]  loopf_q;
  logic signed [15:0] lower_q, res_q;
  logic signed [33:0] mul_q;

  logic accept, out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Zone memory: one write port, one registered read port
  zone_t        zone_mem [NUM_ZONES];
  zone_t        zrd_q;
  logic         zrd_en;
  logic [ZW-1:0] zrd_addr;
  logic         zwr_en;

  assign zwr_en = accept && (req_e'(req_type_i) == REQ_WRITE_ZONE) &&
                  (32'(zone_number_i) < NUM_ZONES);

  always_ff @(posedge clk_i) begin
    if (zwr_en) begin
      zone_mem[ZW'(zone_number_i)] <= '{base: zone_base_i, length: zone_length_i,
                                        loop_pt: loop_point_i, pitch: base_pitch_i};
    end
    if (zrd_en) begin
      zrd_q <= zone_mem[zrd_addr];
    end
  end

  // Sample memory: single port, registered read
  logic [15:0]   smem [SAMPLE_DEPTH];
  logic [15:0]   srd_q;
  logic          srd_en, swr_en;
  logic [AW-1:0] s_addr;
  logic [16:0]   s_off;
  logic [SUMW-1:0] s_sum;

  assign swr_en = accept && (req_e'(req_type_i) == REQ_WRITE_SAMPLE);
  assign s_sum  = SUMW'(zrd_q.base) + SUMW'(s_off);

  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[AW'(mem_address_i)] <= sample_value_i;
    end else if (srd_en) begin
      srd_q <= smem[s_addr];
    end
  end

  // Divider for the pitch ratio
  logic        div_start;
  logic        div_done;
  logic [39:0] div_quo;

  mzsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({note_q, 16'd0}),
    .divisor_i  (best_pitch_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Search bounds: effective zone count and last index
  logic [CW-1:0] cnt_eff;
  logic          single;
  logic [ZW-1:0] last_idx;
  logic [24:0]   pitch_gap;

  always_comb begin
    cnt_eff  = (CW'(zone_count_q) > CW'(NUM_ZONES)) ? CW'(NUM_ZONES) : CW'(zone_count_q);
    single   = (cnt_eff <= CW'(1));
    last_idx = single ? '0 : ZW'(cnt_eff - CW'(1));
    pitch_gap = (zrd_q.pitch > note_q) ? 25'(zrd_q.pitch - note_q)
                                       : 25'(note_q - zrd_q.pitch);
  end

  // Tick position update
  logic [32:0] pos_sum;
  logic [31:0] pos_adv;
  logic [16:0] last_c;
  logic [15:0] loopf_c;
  logic        at_end;
  logic [31:0] pos_new;

  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, prod_q[47:16]};
    if (not_started_q) begin
      pos_adv = '0;
    end else begin
      pos_adv = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
    end
    last_c  = (zrd_q.length == 17'd0) ? 17'd0 : zrd_q.length - 17'd1;
    loopf_c = ({1'b0, zrd_q.loop_pt} > last_c) ? last_c[15:0] : zrd_q.loop_pt;
    at_end  = ({1'b0, pos_adv[31:16]} >= last_c);
    if (!at_end) begin
      pos_new = pos_adv;
    end else if ({1'b0, zrd_q.loop_pt} > last_c) begin
      pos_new = {last_c[15:0], 16'd0};
    end else begin
      pos_new = {zrd_q.loop_pt, pos_adv[15:0]};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_START_PITCH: state_d = ST_SRCH_RD;
            REQ_TICK:        state_d = playing_q ? ST_TK_ZONE : ST_FIN;
            default:         state_d = ST_FIN;
          endcase
        end
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = (srch_idx_q == last_idx) ? ST_DIV_GO : ST_SRCH_RD;
      ST_DIV_GO:   state_d = (best_pitch_q == 24'd0) ? ST_FIN : ST_DIV_WAIT;
      ST_DIV_WAIT: state_d = div_done ? ST_FIN : ST_DIV_WAIT;
      ST_TK_ZONE:  state_d = ST_TK_POS;
      ST_TK_POS:   state_d = (at_end && !loop_mode_q) ? ST_FIN : ST_TK_RDLO;
      ST_TK_RDLO:  state_d = ST_TK_RDUP;
      ST_TK_RDUP:  state_d = ST_TK_MUL;
      ST_TK_MUL:   state_d = ST_TK_SUM;
      ST_TK_SUM:   state_d = ST_FIN;
      ST_FIN:      state_d = out_free ? ST_IDLE : ST_FIN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    zrd_en    = 1'b0;
    zrd_addr  = sel_q;
    srd_en    = 1'b0;
    s_off     = {1'b0, pos_q[31:16]};
    div_start = 1'b0;
    s_addr    = AW'(s_sum);
    case (state_q)
      ST_SRCH_RD: begin
        zrd_en   = 1'b1;
        zrd_addr = srch_idx_q;
      end
      ST_DIV_GO:  div_start = (best_pitch_q != 24'd0);
      ST_TK_ZONE: zrd_en = 1'b1;
      ST_TK_RDLO: srd_en = 1'b1;
      ST_TK_RDUP: begin
        srd_en = 1'b1;
        s_off  = ({1'b0, pos_q[31:16]} == last_q) ? {1'b0, loopf_q}
                                                  : {1'b0, pos_q[31:16]} + 17'd1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      not_started_q <= 1'b1;
      playing_q     <= 1'b0;
      rate_q        <= RATE_ONE;
      sel_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // Raise the result valid in the final state, drop it once taken
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_e'(req_type_i))
              REQ_START_PITCH: begin
                pos_q         <= '0;
                not_started_q <= 1'b1;
                playing_q     <= 1'b1;
              end
              REQ_START_RATE: begin
                pos_q         <= '0;
                not_started_q <= 1'b1;
                playing_q     <= 1'b1;
                sel_q         <= '0;
                rate_q        <= rate_value_i;
              end
              REQ_STOP: begin
                pos_q         <= '0;
                not_started_q <= 1'b1;
                playing_q     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV_GO: begin
          sel_q <= best_idx_q;
          if (best_pitch_q == 24'd0) begin
            rate_q <= RATE_MAX;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            rate_q <= (div_quo[39:24] != 16'd0) ? RATE_MAX : div_quo[23:0];
          end
        end
        ST_TK_POS: begin
          if (at_end && !loop_mode_q) begin
            playing_q     <= 1'b0;
            not_started_q <= 1'b1;
            pos_q         <= '0;
          end else begin
            not_started_q <= 1'b0;
            pos_q         <= pos_new;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        res_q        <= '0;
        note_q       <= note_pitch_i;
        mod_q        <= rate_modifier_i;
        srch_idx_q   <= '0;
        best_idx_q   <= '0;
        smallest_q   <= SEARCH_BOUND;
      end
      ST_SRCH_CMP: begin
        // Zone 0 stays the default when no zone beats the search bound
        if (single || (pitch_gap < smallest_q)) begin
          smallest_q   <= pitch_gap;
          best_idx_q   <= srch_idx_q;
          best_pitch_q <= zrd_q.pitch;
        end else if (srch_idx_q == '0) begin
          best_pitch_q <= zrd_q.pitch;
        end
        srch_idx_q <= srch_idx_q + ZW'(1);
      end
      ST_TK_ZONE: prod_q <= 48'(rate_q) * 48'(mod_q);
      ST_TK_POS: begin
        last_q  <= last_c;
        loopf_q <= loopf_c;
      end
      ST_TK_MUL: begin
        mul_q   <= (34'(signed'(srd_q)) - 34'(lower_q)) * 34'(signed'({1'b0, pos_q[15:0]}));
      end
      ST_TK_RDUP: lower_q <= srd_q;
      ST_TK_SUM: res_q <= 16'(({lower_q, 16'd0} + 32'(mul_q)) >>> 16);
      ST_FIN: begin
        if (out_free) begin
          out_sample_q  <= res_q;
          out_playing_q <= playing_q;
          out_zone_q    <= 3'(sel_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign is_playing_o  = out_playing_q;
  assign active_zone_o = out_zone_q;

endmodule

// ----- rtl/core/mzsp_div.sv -----
// Radix-2 restoring divider: 40-bit dividend by 24-bit divisor, one bit a cycle.
module mzsp_div
  import mzsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [39:0] quotient_o
);

  logic [24:0] rem_q, rem_d;
  logic [39:0] quo_q, quo_d;
  logic [23:0] dvs_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [25:0] trial;
  logic [24:0] shifted;

  // Shift one dividend bit in and try a subtract
  always_comb begin
    shifted = {rem_q[23:0], quo_q[39]};
    trial   = {1'b0, shifted} - {2'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[25]) begin
        rem_d = shifted;
        quo_d = {quo_q[38:0], 1'b0};
      end else begin
        rem_d = trial[24:0];
        quo_d = {quo_q[38:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- dv/tb.sv -----
// Testbench for the multi-zone sample player: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import mzsp_pkg::*;

  // One request as offered on the input channel
  typedef struct {
    req_e              req;
    logic [15:0]       addr;
    logic [15:0]       word;
    logic [2:0]        zone;
    logic [15:0]       base;
    logic [16:0]       length;
    logic [15:0]       loop_pt;
    logic [23:0]       pitch;
    logic [23:0]       note;
    logic [23:0]       rate;
    logic [23:0]       modifier;
  } request_t;

  // One playback result as seen on the output channel
  typedef struct {
    logic [15:0] sample;
    logic        playing;
    logic [2:0]  zone;
  } playback_t;

  // Samples are preloaded into a window that wraps the top of sample memory
  localparam logic [15:0] WIN_START = 16'hFFE0;
  localparam int          WIN_SIZE  = 64;

  // Player model with its own copy of state and configuration
  class player_scoreboard;
    logic [15:0] samples [65536];
    logic [15:0] zbase [8];
    logic [16:0] zlen [8];
    logic [15:0] zloop [8];
    logic [23:0] zpitch [8];
    logic [31:0] position;
    bit          fresh;
    bit          playing;
    logic [23:0] rate;
    logic [2:0]  zone_sel;
    bit          loop_on;
    logic [3:0]  search_count;
    playback_t   expected_q[$];
    int          errors;

    function new();
      position = 0;
      fresh = 1;
      playing = 0;
      rate = RATE_ONE;
      zone_sel = 0;
      loop_on = 0;
      search_count = 1;
      errors = 0;
    endfunction

    function logic [31:0] last_of(logic [2:0] z);
      return (zlen[z] == 0) ? 32'd0 : 32'(zlen[z]) - 1;
    endfunction

    function longint frame_at(logic [2:0] z, logic [31:0] offset);
      logic [15:0] a;
      a = 16'(32'(zbase[z]) + offset);
      return longint'($signed(samples[a]));
    endfunction

    // Blend the frame at the position with its upper neighbour
    function logic [15:0] blend();
      logic [31:0] last, whole, frac, loopf;
      longint lower, upper, acc;
      last = last_of(zone_sel);
      whole = position >> 16;
      frac = position & 32'hFFFF;
      loopf = zloop[zone_sel];
      if (loopf > last) loopf = last;
      lower = frame_at(zone_sel, whole);
      upper = (whole == last) ? frame_at(zone_sel, loopf) : frame_at(zone_sel, whole + 1);
      acc = lower * 65536 + (upper - lower) * longint'(frac) + 64'sd32768 * 65536;
      return 16'((acc >>> 16) - 32768);
    endfunction

    function logic [15:0] play_tick(logic [23:0] modifier);
      logic [63:0] step, sum;
      logic [31:0] last, whole;
      if (!playing) return 16'd0;
      if (fresh) begin
        position = 0;
        fresh = 0;
      end else begin
        step = (64'(rate) * 64'(modifier)) >> 16;
        sum = 64'(position) + step;
        position = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
      end
      last = last_of(zone_sel);
      whole = position >> 16;
      if (whole >= last) begin
        if (!loop_on) begin
          playing = 0;
          fresh = 1;
          position = 0;
          return 16'd0;
        end
        whole = zloop[zone_sel];
        if (whole > last) position = last << 16;
        else position = (whole << 16) | (position & 32'hFFFF);
      end
      return blend();
    endfunction

    function void start_nearest(logic [23:0] note);
      int          count;
      logic [2:0]  best;
      logic [31:0] smallest, d;
      logic [63:0] r;
      count = (search_count > 8) ? 8 : search_count;
      best = 0;
      position = 0;
      fresh = 1;
      playing = 1;
      if (count > 1) begin
        smallest = 32'(SEARCH_BOUND);
        for (int i = 0; i < count; i++) begin
          d = (zpitch[i] > note) ? 32'(zpitch[i] - note) : 32'(note - zpitch[i]);
          if (d < smallest) begin
            smallest = d;
            best = 3'(i);
          end
        end
      end
      zone_sel = best;
      if (zpitch[best] == 0) rate = RATE_MAX;
      else begin
        r = (64'(note) << 16) / 64'(zpitch[best]);
        rate = (r > 64'(RATE_MAX)) ? RATE_MAX : r[23:0];
      end
    endfunction

    // Note an accepted request and queue its expected result
    function void note_request(request_t it);
      playback_t res;
      res.sample = 0;
      case (it.req)
        REQ_WRITE_SAMPLE: samples[it.addr] = it.word;
        REQ_WRITE_ZONE: begin
          zbase[it.zone] = it.base;
          zlen[it.zone] = it.length;
          zloop[it.zone] = it.loop_pt;
          zpitch[it.zone] = it.pitch;
        end
        REQ_START_PITCH: start_nearest(it.note);
        REQ_START_RATE: begin
          position = 0;
          fresh = 1;
          playing = 1;
          zone_sel = 0;
          rate = it.rate;
        end
        REQ_STOP: begin
          playing = 0;
          fresh = 1;
          position = 0;
        end
        REQ_TICK: res.sample = play_tick(it.modifier);
        default: ;
      endcase
      res.playing = playing;
      res.zone = zone_sel;
      expected_q.insert(expected_q.size(), res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result with the oldest expectation
    task check_result(playback_t got);
      playback_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      exp = expected_q.pop_front();
      if (got.sample !== exp.sample)
        report_mismatch($sformatf("sample_out %0d, want %0d",
                                  $signed(got.sample), $signed(exp.sample)));
      if (got.playing !== exp.playing)
        report_mismatch($sformatf("is_playing %0b, want %0b", got.playing, exp.playing));
      if (got.zone !== exp.zone)
        report_mismatch($sformatf("active_zone %0d, want %0d", got.zone, exp.zone));
    endtask
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = 0;
  logic [15:0]        mem_address_i = 0;
  logic signed [15:0] sample_value_i = 0;
  logic [2:0]         zone_number_i = 0;
  logic [15:0]        zone_base_i = 0;
  logic [16:0]        zone_length_i = 0;
  logic [15:0]        loop_point_i = 0;
  logic [23:0]        base_pitch_i = 0;
  logic [23:0]        note_pitch_i = 0;
  logic [23:0]        rate_value_i = 0;
  logic [23:0]        rate_modifier_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [15:0] sample_out_o;
  logic               is_playing_o;
  logic [2:0]         active_zone_o;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  player_scoreboard sb;
  bit               calm = 0;
  bit               hold_req = 0;

  multi_zone_sample_player dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
        out_stall_i = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 0;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{sample_out_o, is_playing_o, active_zone_o});
  end

  // Request with every field random; callers pin down what matters
  function automatic request_t any_request(req_e req);
    request_t it;
    it.req = req;
    it.addr = 16'($urandom);
    it.word = 16'($urandom);
    it.zone = 3'($urandom);
    it.base = 16'($urandom);
    it.length = 17'($urandom);
    it.loop_pt = 16'($urandom);
    it.pitch = 24'($urandom);
    it.note = 24'($urandom);
    it.rate = 24'($urandom);
    it.modifier = 24'($urandom);
    return it;
  endfunction

  // Zone write that stays inside the preloaded window
  function automatic request_t zone_write(logic [2:0] z);
    request_t it;
    int off;
    it = any_request(REQ_WRITE_ZONE);
    off = $urandom_range(0, WIN_SIZE - 2);
    it.zone = z;
    it.base = WIN_START + 16'(off);
    it.length = 17'($urandom_range(2, WIN_SIZE - off));
    it.loop_pt = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                 : 16'($urandom_range(0, int'(it.length) + 2));
    it.pitch = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
               : 24'($urandom_range(256 * 50, 256 * 4000));
    return it;
  endfunction

  function automatic request_t sample_write(bit anywhere);
    request_t it;
    it = any_request(REQ_WRITE_SAMPLE);
    if (!anywhere) it.addr = WIN_START + 16'($urandom_range(0, WIN_SIZE - 1));
    return it;
  endfunction

  function automatic request_t tick_req();
    request_t it;
    it = any_request(REQ_TICK);
    if ($urandom_range(0, 15) != 0) it.modifier = 24'($urandom_range(24'h4000, 24'h30000));
    return it;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send(request_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i = 1;
    req_type_i = it.req;
    mem_address_i = it.addr;
    sample_value_i = it.word;
    zone_number_i = it.zone;
    zone_base_i = it.base;
    zone_length_i = it.length;
    loop_point_i = it.loop_pt;
    base_pitch_i = it.pitch;
    note_pitch_i = it.note;
    rate_value_i = it.rate;
    rate_modifier_i = it.modifier;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_request(it);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Register write over the APB port
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic configure(bit loop_on, logic [3:0] count);
    wait_drained();
    reg_write({CFG_LOOP_MODE, 2'b00}, {31'($urandom), loop_on});
    reg_write({CFG_ZONE_COUNT, 2'b00}, {28'($urandom), count});
    sb.loop_on = loop_on;
    sb.search_count = count;
  endtask

  // Random well-formed playback sequences plus noise
  task automatic random_phase(int n);
    request_t it;
    int sent;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0: it = sample_write($urandom_range(0, 5) == 0);
        1: it = zone_write(3'($urandom));
        2: begin
          it = any_request(REQ_STOP);
          if ($urandom_range(0, 3) == 0) it.req = $urandom_range(0, 1) ? REQ_NOP6 : REQ_NOP7;
        end
        default: begin
          it = any_request($urandom_range(0, 1) ? REQ_START_PITCH : REQ_START_RATE);
          if ($urandom_range(0, 7) != 0) begin
            it.note = 24'($urandom_range(256 * 50, 256 * 4000));
            it.rate = 24'($urandom_range(24'h4000, 24'h30000));
          end
          send(it);
          sent++;
          repeat ($urandom_range(3, 60)) begin
            send(tick_req());
            sent++;
          end
          continue;
        end
      endcase
      send(it);
      sent++;
    end
  endtask

  initial begin
    request_t it;
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Preload the sample window, extremes included
    for (int i = 0; i < WIN_SIZE; i++) begin
      it = any_request(REQ_WRITE_SAMPLE);
      it.addr = WIN_START + 16'(i);
      if (i == 1) it.word = 16'h8000;
      if (i == 2) it.word = 16'h7FFF;
      send(it);
    end
    for (int z = 0; z < 8; z++) send(zone_write(3'(z)));

    // Largest zone descriptor; replaced before anything can play it
    it = any_request(REQ_WRITE_ZONE);
    it.zone = 3'd7;
    it.base = 16'hFFFF;
    it.length = 17'h10000;
    it.loop_pt = 16'hFFFF;
    it.pitch = 24'hFFFFFF;
    send(it);
    it = zone_write(3'd7);
    it.length = 17'd2;
    it.base = WIN_START;
    it.pitch = 24'd1;
    send(it);
    // Tie on equal pitches: the first zone must win
    it = zone_write(3'd3);
    it.pitch = 24'd256 * 440;
    send(it);
    it = zone_write(3'd4);
    it.pitch = 24'd256 * 440;
    send(it);

    // Directed: rate extremes, saturating step, stop, nops, idle tick
    send(any_request(REQ_TICK));
    it = any_request(REQ_START_RATE);
    it.rate = RATE_ONE;
    send(it);
    repeat (3) send(tick_req());
    it = any_request(REQ_TICK);
    it.modifier = 24'hFFFFFF;
    send(it);
    it = any_request(REQ_START_RATE);
    it.rate = 24'd0;
    send(it);
    repeat (2) send(tick_req());
    it.rate = 24'hFFFFFF;
    send(it);
    it = any_request(REQ_TICK);
    it.modifier = 24'd0;
    send(it);
    send(tick_req());
    it = any_request(REQ_START_PITCH);
    it.note = 24'd0;
    send(it);
    it.note = 24'hFFFFFF;
    send(it);
    send(tick_req());
    send(any_request(REQ_STOP));
    send(any_request(REQ_NOP6));
    send(any_request(REQ_NOP7));

    // Search over all zones, ties and extremes of the note
    configure(1, 4'd8);
    it = any_request(REQ_START_PITCH);
    it.note = 24'd256 * 440;
    send(it);
    repeat (4) send(tick_req());
    it.note = 24'd0;
    send(it);
    it.note = 24'hFFFFFF;
    send(it);

    // Random phases over several settings; one long receiver hold-off
    hold_req = 1;
    random_phase(300);
    configure(0, 4'd1);
    random_phase(300);
    configure(1, 4'd15);
    random_phase(300);
    configure(0, 4'd0);
    random_phase(250);
    configure(1, 4'd3);
    random_phase(250);
    configure(1, 4'd8);
    calm = 1;
    random_phase(300);

    // Drain, then check for leftover expectations
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report_mismatch("expected results never arrived");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mzsp_pkg.sv
rtl/core/mzsp_div.sv
rtl/core/multi_zone_sample_player.sv
dv/tb.sv
